// ===== src/slt_pkg.sv =====
// slt_pkg: constants, types and helpers shared by the shell-like tokenizer
// no dependencies
`default_nettype none

package slt_pkg;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one queue entry: the byte and what it produces
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       token_end;
    } t_entry;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0C, 8'h0D};
    endfunction

endpackage

`default_nettype wire

// ===== src/slt_front.sv =====
// slt_front: scanning state and per-byte classification
// depends on slt_pkg
`default_nettype none

module slt_front
    import slt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eos,
    output logic            o_push,
    output t_entry          o_entry
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_QUOTE = 2'd2
    } t_mode;

    t_mode      r_mode, n_mode;
    logic       r_single, n_single;
    logic       r_esc, n_esc;
    logic       emit_byte, emit_end;
    logic [7:0] close_q;

    always_comb begin
        n_mode    = r_mode;
        n_single  = r_single;
        n_esc     = r_esc;
        emit_byte = 1'b0;
        emit_end  = 1'b0;
        close_q   = r_single ? CH_SQUOTE : CH_DQUOTE;
        case (r_mode)
            MODE_WORD: begin
                if (is_space(i_byte)) begin
                    emit_end = 1'b1;
                    n_mode   = MODE_IDLE;
                end else begin
                    emit_byte = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (r_esc) begin
                    emit_byte = 1'b1;
                    n_esc     = 1'b0;
                end else if (i_byte == close_q) begin
                    emit_end = 1'b1;
                    n_mode   = MODE_IDLE;
                end else if (i_byte == CH_BSLASH && !i_eos) begin
                    n_esc = 1'b1;
                end else begin
                    emit_byte = 1'b1;
                end
            end
            default: begin
                n_esc = 1'b0;
                if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                    n_mode   = MODE_QUOTE;
                    n_single = (i_byte == CH_SQUOTE);
                end else if (!is_space(i_byte)) begin
                    emit_byte = 1'b1;
                    n_mode    = MODE_WORD;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
        endcase
        // string end closes any open token and restarts
        if (i_eos) begin
            if (n_mode != MODE_IDLE) begin
                emit_end = 1'b1;
            end
            n_mode   = MODE_IDLE;
            n_single = 1'b0;
            n_esc    = 1'b0;
        end
    end

    assign o_push            = i_accept && (emit_byte || emit_end);
    assign o_entry.data      = i_byte;
    assign o_entry.has_byte  = emit_byte;
    assign o_entry.token_end = emit_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_single <= 1'b0;
            r_esc    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_single <= n_single;
            r_esc    <= n_esc;
        end
    end

`ifndef ASSERT_OFF
    a_eos_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eos) |=> (r_mode == MODE_IDLE && !r_esc && !r_single))
        else $error("scanner not back to idle after string end");
    a_esc_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_mode == MODE_QUOTE))
        else $error("escape pending outside quotes");
`endif

endmodule

`default_nettype wire

// ===== src/slt_queue.sv =====
// slt_queue: short queue of classified entries between front and back
// depends on slt_pkg
`default_nettype none

module slt_queue
    import slt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_entry    i_wr_entry,
    input  wire logic i_rd,
    output t_entry    o_rd_entry,
    output logic      o_full,
    output logic      o_empty
);

    localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_wr, do_rd;

    assign o_full     = (r_count == DEPTH_CNT);
    assign o_empty    = (r_count == '0);
    assign do_wr      = i_wr && !o_full;
    assign do_rd      = i_rd && !o_empty;
    assign o_rd_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== src/slt_back.sv =====
// slt_back: expands each queue entry into its byte and token-end results
// depends on slt_pkg
`default_nettype none

module slt_back
    import slt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_empty,
    input  t_entry          i_q_entry,
    output logic            o_q_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_token_end,
    output logic            o_run_last
);

    t_entry r_ent;
    logic   r_valid;
    logic   r_second;
    logic   show_byte, take, load;

    // byte result goes first, token end second
    assign show_byte   = r_ent.has_byte && !r_second;
    assign o_empty     = !r_valid;
    assign o_out_byte  = show_byte ? r_ent.data : 8'd0;
    assign o_has_byte  = show_byte;
    assign o_token_end = !show_byte;
    assign o_run_last  = !(show_byte && r_ent.token_end);

    assign take    = i_pop && r_valid;
    assign load    = !r_valid || (take && o_run_last);
    assign o_q_pop = load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_q_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= !i_q_empty;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_second_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && r_ent.has_byte && r_ent.token_end))
        else $error("second result without a two-result entry");
    a_entry_not_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_ent.has_byte || r_ent.token_end))
        else $error("entry held that produces no result");
`endif

endmodule

`default_nettype wire

// ===== src/shell_like_tokenizer.sv =====
// shell_like_tokenizer: top level, front scanner, entry queue and result expander
// depends on slt_pkg, slt_front, slt_queue, slt_back
`default_nettype none

// Splits a byte stream into shell-style tokens, one input byte per item.
// Whitespace (space, tab, LF, FF, CR) separates words; a single or double
// quote seen between tokens opens a quoted token that runs to the matching
// quote, with backslash escaping the next byte inside quotes (a backslash that
// is the final byte of the string is kept as is). Each token byte comes out as
// one result item, and every token is closed by a separate token-end item;
// run_last marks the last result of each input byte. The front scanner takes a
// byte in every cycle while full is low and writes an entry into a four-deep
// queue only when the byte produces something; the back expander turns each
// entry into one or two result items, one per cycle while pop is held. So
// input runs at one byte a cycle while full is low, output at one result a
// cycle while pop is held and a result is ready, and a byte giving two
// results (a byte plus token end at string end) presents them as two items.
// A result reaches the output through the queue entry and then the output
// register of the back expander. Bytes that produce nothing (whitespace between
// tokens, opening quotes, escaping backslashes) are taken but write no entry.
module shell_like_tokenizer
    import slt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_string,
    // result side
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_token_end,
    output logic            o_run_last
);

    logic   accept;
    logic   f_push;
    t_entry f_entry;
    t_entry q_entry;
    logic   q_pop, q_empty, q_full;

    // item taken whenever the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: scanning state, decides byte and token-end per item
    slt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_eos    (i_end_of_string),
        .o_push   (f_push),
        .o_entry  (f_entry)
    );

    // decoupling queue, lets a stalled consumer not block the scanner at once
    slt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (f_push),
        .i_wr_entry (f_entry),
        .i_rd       (q_pop),
        .o_rd_entry (q_entry),
        .o_full     (q_full),
        .o_empty    (q_empty)
    );

    // back: holds the current entry and presents its results in order
    slt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_token_end (o_token_end),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire

// ===== sim/slt_tb_pkg.sv =====
// slt_tb_pkg: result type, whitespace codes and the token scoreboard for the tokenizer bench
// depends on slt_pkg for the quote and backslash codes
`timescale 1ns / 1ps

package slt_tb_pkg;

    import slt_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        SCAN_IDLE  = 2'd0,
        SCAN_WORD  = 2'd1,
        SCAN_QUOTE = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       token_end;
        logic       run_last;
    } t_tok_result;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR;
    endfunction

    class token_scoreboard;
        t_scan_mode  mode;
        logic        in_single;
        logic        esc_pending;
        t_tok_result awaited[$];
        int          mismatches;

        function new();
            mode        = SCAN_IDLE;
            in_single   = 1'b0;
            esc_pending = 1'b0;
            mismatches  = 0;
        endfunction

        // advance the tokenizer state by one accepted byte and queue what it yields
        function void note_byte(input logic [7:0] c, input logic eos);
            logic        emit_b;
            logic        emit_e;
            logic [7:0]  closer;
            emit_b = 1'b0;
            emit_e = 1'b0;
            case (mode)
                SCAN_WORD: begin
                    if (is_blank(c)) begin
                        emit_e = 1'b1;
                        mode   = SCAN_IDLE;
                    end else begin
                        emit_b = 1'b1;
                    end
                end
                SCAN_QUOTE: begin
                    closer = in_single ? CH_SQUOTE : CH_DQUOTE;
                    if (esc_pending) begin
                        emit_b      = 1'b1;
                        esc_pending = 1'b0;
                    end else if (c == closer) begin
                        emit_e = 1'b1;
                        mode   = SCAN_IDLE;
                    end else if (c == CH_BSLASH && !eos) begin
                        esc_pending = 1'b1;
                    end else begin
                        emit_b = 1'b1;
                    end
                end
                default: begin
                    esc_pending = 1'b0;
                    if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        mode      = SCAN_QUOTE;
                        in_single = (c == CH_SQUOTE);
                    end else if (!is_blank(c)) begin
                        emit_b = 1'b1;
                        mode   = SCAN_WORD;
                    end else begin
                        mode = SCAN_IDLE;
                    end
                end
            endcase
            if (eos) begin
                if (mode != SCAN_IDLE)
                    emit_e = 1'b1;
                mode        = SCAN_IDLE;
                in_single   = 1'b0;
                esc_pending = 1'b0;
            end
            if (emit_b)
                awaited.insert(awaited.size(),
                               t_tok_result'{data: c, has_byte: 1'b1, token_end: 1'b0,
                                             run_last: !emit_e});
            if (emit_e)
                awaited.insert(awaited.size(),
                               t_tok_result'{data: 8'h00, has_byte: 1'b0, token_end: 1'b1,
                                             run_last: 1'b1});
        endfunction

        function void flag(input string what, input t_tok_result want,
                           input t_tok_result got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"mismatch %0d (%s): expected data=%h has=%b end=%b last=%b,",
                          " got data=%h has=%b end=%b last=%b"},
                         mismatches, what, want.data, want.has_byte, want.token_end,
                         want.run_last, got.data, got.has_byte, got.token_end, got.run_last);
        endfunction

        // compare one popped result with the oldest expected one
        function void check_result(input t_tok_result got);
            t_tok_result want;
            if (awaited.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.data !== want.data || got.has_byte !== want.has_byte ||
                got.token_end !== want.token_end || got.run_last !== want.run_last)
                flag("wrong field", want, got);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

endpackage

// ===== sim/shell_like_tokenizer_tb.sv =====
// shell_like_tokenizer_tb: top-level bench, drives bytes and pops results of the tokenizer
// depends on slt_pkg, slt_tb_pkg and the shell_like_tokenizer rtl
`timescale 1ns / 1ps

module shell_like_tokenizer_tb;

    import slt_pkg::*;
    import slt_tb_pkg::*;

    // generous: well above what the slowest correct run needs
    localparam int CYCLE_LIMIT  = 200000;
    // results pass the queue and the output register, so a short settle suffices
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 225;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       i_end_of_string;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_token_end;
    logic       o_run_last;

    token_scoreboard token_sb;
    t_tok_result     popped;
    int              sent_items;
    int              cycles;
    // per-phase idling, in percent of cycles
    int              sender_idle_pct;
    int              recv_stall_pct;

    shell_like_tokenizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_token_end     (o_token_end),
        .o_run_last      (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: decide at each falling edge whether to pop in the coming cycle
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // every popped result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            popped = '{data: o_out_byte, has_byte: o_has_byte,
                       token_end: o_token_end, run_last: o_run_last};
            token_sb.check_result(popped);
        end
    end

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // biased towards the bytes the scanner treats specially
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return CH_DQUOTE;
            1:       return CH_SQUOTE;
            2:       return CH_BSLASH;
            3:       return blank_byte();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_in_byte       <= b;
        i_end_of_string <= eos;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        token_sb.note_byte(b, eos);
        sent_items++;
        @(negedge i_clk);
    endtask

    // a well-formed string: words and quoted tokens split by whitespace,
    // occasionally with an unterminated quote, end flag on the last byte
    task automatic send_string();
        logic [7:0] text[$];
        logic [7:0] q;
        logic [7:0] b;
        int         ntok;
        int         len;
        ntok = $urandom_range(1, 5);
        for (int t = 0; t < ntok; t++) begin
            repeat ($urandom_range(0, 2)) text.insert(text.size(), blank_byte());
            if ($urandom_range(1)) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    // a leading quote would open a quoted token instead of a word
                    do b = pick_byte();
                    while (is_blank(b) || (k == 0 && (b == CH_DQUOTE || b == CH_SQUOTE)));
                    text.insert(text.size(), b);
                end
                text.insert(text.size(), blank_byte());
            end else begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                text.insert(text.size(), q);
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(3) == 0) begin
                        text.insert(text.size(), CH_BSLASH);
                        text.insert(text.size(), pick_byte());
                    end else begin
                        do b = pick_byte();
                        while (b == q || b == CH_BSLASH);
                        text.insert(text.size(), b);
                    end
                end
                if ($urandom_range(7) != 0)
                    text.insert(text.size(), q);
                else if ($urandom_range(1))
                    text.insert(text.size(), CH_BSLASH);
            end
        end
        if ($urandom_range(3) == 0)
            text.insert(text.size(), blank_byte());
        foreach (text[i])
            send_item(text[i], i == text.size() - 1);
    endtask

    // noise: loose bytes with a stray end flag now and then
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            send_item(pick_byte(), $urandom_range(15) == 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        target          = sent_items + PHASE_ITEMS;
        while (sent_items < target) begin
            if ($urandom_range(4) == 0)
                send_noise();
            else
                send_string();
        end
    endtask

    initial begin
        token_sb        = new();
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        i_in_byte       = 8'h00;
        i_end_of_string = 1'b0;
        sent_items      = 0;
        cycles          = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, no idling
        send_item(CH_SPACE,  1'b0);     // whitespace between tokens, nothing out
        send_item(8'h61,     1'b0);     // word opens
        send_item(CH_DQUOTE, 1'b0);     // quote inside a word is plain
        send_item(8'hFF,     1'b0);
        send_item(CH_TAB,    1'b0);     // ends the word
        send_item(CH_SQUOTE, 1'b0);     // single-quoted token opens
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_SQUOTE, 1'b0);     // escaped quote kept literally
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_BSLASH, 1'b0);     // escaped backslash
        send_item(CH_DQUOTE, 1'b0);     // other quote kind is plain inside
        send_item(CH_SQUOTE, 1'b0);     // closing quote, token end only
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_DQUOTE, 1'b0);     // empty quoted token
        send_item(CH_LF,     1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_item(8'h00,     1'b0);
        send_item(CH_BSLASH, 1'b1);     // final backslash in quotes kept, then token end
        send_item(CH_SQUOTE, 1'b1);     // quote opening at string end
        send_item(8'h00,     1'b1);     // one-byte word closed by the end flag
        send_item(CH_FF,     1'b1);     // blank string end, nothing out
        send_item(8'h7E,     1'b0);
        send_item(CH_CR,     1'b1);     // word ended by whitespace that also ends the string
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(8'h80,     1'b1);     // escaped byte at string end, unterminated quote

        // random part over the idling phases
        run_phase(0, 0);
        run_phase(45, 0);
        run_phase(0, 45);
        run_phase(19, 19);

        push <= 1'b0;
        while (token_sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (token_sb.mismatches == 0 && token_sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/slt_pkg.sv
src/slt_front.sv
src/slt_queue.sv
src/slt_back.sv
src/shell_like_tokenizer.sv
sim/slt_tb_pkg.sv
sim/shell_like_tokenizer_tb.sv
